### hw/rtl/tournament_branch_predictor_unit_macros.svh
// Assertion macros for the tournament branch predictor.
// Used by the top level only; no other dependencies.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_UNIT_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_UNIT_MACROS_SVH

// Antecedent implies consequent in the same cycle (the consequent may carry a delay).
`define TBP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("tournament branch predictor: assertion failed");

// Antecedent implies consequent in the next cycle.
`define TBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tournament branch predictor: assertion failed");

`endif

### hw/rtl/tbp_pkg.sv
// Shared constants and helper functions for the tournament branch predictor.
// No dependencies.
`timescale 1ns / 1ps

package tbp_pkg;

   localparam int TABLE_ENTRIES_DEF = 2048;
   localparam int HISTORY_BITS_DEF  = 11;

   localparam int CTR_W      = 2;
   localparam int HIST_LEN_W = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CTR_W-1:0]      CTR_MAX         = 2'd3;
   localparam logic [CTR_W-1:0]      CTR_MIN         = 2'd0;
   localparam logic [CTR_W-1:0]      CTR_INIT_PRED   = 2'd1;
   localparam logic [CTR_W-1:0]      CTR_INIT_CHOOSE = 2'd2;
   localparam logic [HIST_LEN_W-1:0] HIST_LEN_RESET  = 4'd11;

   // Register index, taken from the word address of the configuration port.
   localparam logic CSR_IDX_HIST_LEN = 1'b0;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // Two-bit saturating counter step toward the outcome.
   function automatic logic [CTR_W-1:0] sat_move(input logic [CTR_W-1:0] v,
                                                 input logic up);
      logic [CTR_W-1:0] r;
      if (up) begin
         r = (v == CTR_MAX) ? CTR_MAX : v + 2'd1;
      end else begin
         r = (v == CTR_MIN) ? CTR_MIN : v - 2'd1;
      end
      return r;
   endfunction

endpackage

### hw/rtl/tournament_branch_predictor_unit.sv
// Tournament branch predictor (gshare and bimodal with a per-address chooser).
// Depends on tbp_pkg, tbp_csr, tbp_ctr_ram and the assertion macro header.
// Usage: one resolved branch is taken on each clock edge where start is high
// and busy is low, so a new branch may be given every cycle. Its result
// appears on the rsp_ ports for one cycle, marked by rsp_strobe; the receiver
// cannot stall it. On its way it passes the registered read of the three
// counter memories and then the update and write-back stage. After reset,
// busy stays high while the memories are swept to their reset values, one
// entry per cycle; configuration writes are taken during that time.
// TABLE_ENTRIES must be a power of two.
`timescale 1ns / 1ps
`include "tournament_branch_predictor_unit_macros.svh"

module tournament_branch_predictor_unit #(
   parameter int TABLE_ENTRIES = tbp_pkg::TABLE_ENTRIES_DEF,
   parameter int HISTORY_BITS  = tbp_pkg::HISTORY_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [31:0]                     req_branch_address,
   input  logic                            req_taken,
   output logic                            rsp_strobe,
   output logic                            rsp_prediction,
   output logic                            rsp_correct,
   output logic                            rsp_used_bimodal,
   output logic [31:0]                     rsp_correct_total,
   output logic [31:0]                     rsp_branch_total,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tbp_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tbp_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tbp_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import tbp_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   logic [HIST_LEN_W-1:0]   hist_len;
   logic [HISTORY_BITS-1:0] hist_mask;
   logic [HISTORY_BITS-1:0] hist_cur;
   logic [HISTORY_BITS-1:0] hist_ff, hist_in;
   logic [IDX_W-1:0]        hist_idx;
   logic [IDX_W-1:0]        bidx, gidx;
   logic                    accept;

   logic                    clearing_ff;
   logic [IDX_W-1:0]        clr_idx_ff;

   logic                    s1_valid_ff;
   logic                    s1_taken_ff;
   logic [IDX_W-1:0]        s1_bidx_ff, s1_gidx_ff;

   logic [CTR_W-1:0]        g_ctr, b_ctr, c_ctr;
   logic [CTR_W-1:0]        g_new, b_new, c_new;
   logic                    gpred, bpred, use_b, pred, gok, bok, ok;

   logic                    g_wr_en, b_wr_en, c_wr_en;
   logic [IDX_W-1:0]        g_wr_addr, b_wr_addr;
   logic [CTR_W-1:0]        g_wr_data, b_wr_data, c_wr_data;

   logic [31:0]             correct_count_ff, correct_count_in;
   logic [31:0]             branch_count_ff, branch_count_in;

   logic                    rsp_strobe_ff;
   logic                    rsp_prediction_ff, rsp_correct_ff, rsp_used_bimodal_ff;
   logic [31:0]             rsp_correct_total_ff, rsp_branch_total_ff;

   tbp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .hist_len (hist_len)
   );

   // ---------------- Front: index computation and history ----------------

   always_comb begin
      for (int i = 0; i < HISTORY_BITS; i++) begin
         hist_mask[i] = (int'(hist_len) > i);
      end
   end

   assign hist_cur = hist_ff & hist_mask;

   // History bits above the table index width are dropped from the gshare index.
   for (genvar g = 0; g < IDX_W; g++) begin : g_hist_idx
      if (g < HISTORY_BITS) begin : g_bit
         assign hist_idx[g] = hist_cur[g];
      end else begin : g_zero
         assign hist_idx[g] = 1'b0;
      end
   end

   assign busy   = clearing_ff;
   assign accept = start && !clearing_ff;
   assign bidx   = req_branch_address[IDX_W-1:0];
   assign gidx   = bidx ^ hist_idx;

   // The history only depends on outcomes, so it advances at acceptance and
   // the next branch sees it right away.
   assign hist_in = accept ?
      (((hist_cur << 1) | HISTORY_BITS'(req_taken)) & hist_mask) : hist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff     <= '0;
         s1_valid_ff <= 1'b0;
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         hist_ff     <= hist_in;
         s1_valid_ff <= accept;
         if (clearing_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_taken_ff <= req_taken;
      s1_bidx_ff  <= bidx;
      s1_gidx_ff  <= gidx;
   end

   // ---------------- Counter memories ----------------

   tbp_ctr_ram #(.DEPTH(TABLE_ENTRIES)) u_gshare_ram (
      .clock   (clock),
      .rd_addr (gidx),
      .rd_data (g_ctr),
      .wr_en   (g_wr_en),
      .wr_addr (g_wr_addr),
      .wr_data (g_wr_data)
   );

   tbp_ctr_ram #(.DEPTH(TABLE_ENTRIES)) u_bimodal_ram (
      .clock   (clock),
      .rd_addr (bidx),
      .rd_data (b_ctr),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (b_wr_data)
   );

   tbp_ctr_ram #(.DEPTH(TABLE_ENTRIES)) u_chooser_ram (
      .clock   (clock),
      .rd_addr (bidx),
      .rd_data (c_ctr),
      .wr_en   (c_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (c_wr_data)
   );

   // ---------------- Update stage ----------------

   always_comb begin
      gpred = g_ctr[1];
      bpred = b_ctr[1];
      use_b = c_ctr[1];
      pred  = use_b ? bpred : gpred;
      gok   = (gpred == s1_taken_ff);
      bok   = (bpred == s1_taken_ff);
      ok    = (pred == s1_taken_ff);

      g_new = sat_move(g_ctr, s1_taken_ff);
      b_new = sat_move(b_ctr, s1_taken_ff);
      if (bok && !gok) begin
         c_new = sat_move(c_ctr, 1'b1);
      end else if (gok && !bok) begin
         c_new = sat_move(c_ctr, 1'b0);
      end else begin
         c_new = c_ctr;
      end
   end

   // The reset sweep and the update stage never overlap: nothing is accepted
   // while the sweep runs.
   always_comb begin
      if (clearing_ff) begin
         g_wr_addr = clr_idx_ff;
         b_wr_addr = clr_idx_ff;
         g_wr_data = CTR_INIT_PRED;
         b_wr_data = CTR_INIT_PRED;
         c_wr_data = CTR_INIT_CHOOSE;
      end else begin
         g_wr_addr = s1_gidx_ff;
         b_wr_addr = s1_bidx_ff;
         g_wr_data = g_new;
         b_wr_data = b_new;
         c_wr_data = c_new;
      end
      g_wr_en = clearing_ff || s1_valid_ff;
      b_wr_en = clearing_ff || s1_valid_ff;
      c_wr_en = clearing_ff || s1_valid_ff;
   end

   always_comb begin
      correct_count_in = correct_count_ff;
      branch_count_in  = branch_count_ff;
      if (s1_valid_ff) begin
         if (ok && (correct_count_ff != COUNT_MAX)) begin
            correct_count_in = correct_count_ff + 32'd1;
         end
         if (branch_count_ff != COUNT_MAX) begin
            branch_count_in = branch_count_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         correct_count_ff <= '0;
         branch_count_ff  <= '0;
         rsp_strobe_ff    <= 1'b0;
      end else begin
         correct_count_ff <= correct_count_in;
         branch_count_ff  <= branch_count_in;
         rsp_strobe_ff    <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_prediction_ff    <= pred;
      rsp_correct_ff       <= ok;
      rsp_used_bimodal_ff  <= use_b;
      rsp_correct_total_ff <= correct_count_in;
      rsp_branch_total_ff  <= branch_count_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_prediction    = rsp_prediction_ff;
   assign rsp_correct       = rsp_correct_ff;
   assign rsp_used_bimodal  = rsp_used_bimodal_ff;
   assign rsp_correct_total = rsp_correct_total_ff;
   assign rsp_branch_total  = rsp_branch_total_ff;

   // ---------------- Assertions ----------------

   `TBP_ASSERT_IMPLY(a_accept_to_result, clock, reset, start && !busy, ##2 rsp_strobe)
   `TBP_ASSERT_IMPLY(a_correct_le_total, clock, reset, rsp_strobe, rsp_correct_total <= rsp_branch_total)
   `TBP_ASSERT_NEXT(a_no_result_while_sweeping, clock, reset, busy, !s1_valid_ff)

endmodule

### hw/rtl/tbp_csr.sv
// Configuration register block: holds the history length behind an APB-style port.
// Depends on tbp_pkg.
`timescale 1ns / 1ps

module tbp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tbp_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tbp_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tbp_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output logic [tbp_pkg::HIST_LEN_W-1:0]  hist_len
);
   import tbp_pkg::*;

   logic [HIST_LEN_W-1:0] hist_len_ff;
   logic                  wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == CSR_IDX_HIST_LEN);

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_len_ff <= HIST_LEN_RESET;
      end else if (wr_hit) begin
         hist_len_ff <= pwdata[HIST_LEN_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_HIST_LEN) begin
         prdata[HIST_LEN_W-1:0] = hist_len_ff;
      end
   end

   assign hist_len = hist_len_ff;

endmodule

### hw/rtl/tbp_ctr_ram.sv
// Counter memory: one write and one registered read per cycle, with a bypass
// for a write to the address being read at the same edge. Depends on tbp_pkg.
`timescale 1ns / 1ps

module tbp_ctr_ram #(
   parameter int DEPTH = tbp_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic [$clog2(DEPTH)-1:0]    rd_addr,
   output logic [tbp_pkg::CTR_W-1:0]   rd_data,
   input  logic                        wr_en,
   input  logic [$clog2(DEPTH)-1:0]    wr_addr,
   input  logic [tbp_pkg::CTR_W-1:0]   wr_data
);
   import tbp_pkg::*;

   logic [CTR_W-1:0] mem [DEPTH];
   logic [CTR_W-1:0] rd_q_ff;
   logic             byp_hit_ff;
   logic [CTR_W-1:0] byp_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // The memory returns the old word on a same-edge collision, so the new
   // word is kept aside and substituted.
   always_ff @(posedge clock) begin
      rd_q_ff     <= mem[rd_addr];
      byp_hit_ff  <= wr_en && (wr_addr == rd_addr);
      byp_data_ff <= wr_data;
   end

   assign rd_data = byp_hit_ff ? byp_data_ff : rd_q_ff;

endmodule

### verif/tournament_branch_predictor_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the tournament branch predictor unit: directed and random
// branch streams, history length changes and register access, checked against mirrored state.
// Depends on tbp_pkg and tournament_branch_predictor_unit.
module tournament_branch_predictor_unit_test;
   import tbp_pkg::*;

   localparam int ENTRIES      = TABLE_ENTRIES_DEF;
   localparam int IDX_W        = $clog2(ENTRIES);
   localparam int HIST_W       = HISTORY_BITS_DEF;
   localparam int IDLE_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 8;
   localparam int POOL         = 24;
   localparam int PHASE_ITEMS  = 105;

   localparam logic [CSR_ADDR_W-1:0] ADDR_HIST_LEN = {CSR_IDX_HIST_LEN, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED = {~CSR_IDX_HIST_LEN, 2'b00};

   typedef struct packed {
      logic        prediction;
      logic        correct;
      logic        used_bimodal;
      logic [31:0] correct_total;
      logic [31:0] branch_total;
   } branch_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [31:0]           req_branch_address = '0;
   logic                  req_taken = 1'b0;
   logic                  rsp_strobe;
   logic                  rsp_prediction;
   logic                  rsp_correct;
   logic                  rsp_used_bimodal;
   logic [31:0]           rsp_correct_total;
   logic [31:0]           rsp_branch_total;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Predictor state mirrored in the testbench.
   logic [CTR_W-1:0]      gshare_ctr  [ENTRIES];
   logic [CTR_W-1:0]      bimodal_ctr [ENTRIES];
   logic [CTR_W-1:0]      chooser_ctr [ENTRIES];
   logic [HIST_W-1:0]     global_hist;
   logic [HIST_LEN_W-1:0] hist_len;
   logic [31:0]           correct_cnt;
   logic [31:0]           branch_cnt;

   branch_result_type expected_results[$];
   int  error_count = 0;
   int  sent_count = 0;
   int  idle_cycles = 0;
   bit  idle_enabled = 1'b0;

   logic [31:0] pool_addr    [POOL];
   logic [7:0]  pool_pattern [POOL];
   int          pool_period  [POOL];
   int          pool_pos     [POOL];

   tournament_branch_predictor_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_branch_address (req_branch_address),
      .req_taken          (req_taken),
      .rsp_strobe         (rsp_strobe),
      .rsp_prediction     (rsp_prediction),
      .rsp_correct        (rsp_correct),
      .rsp_used_bimodal   (rsp_used_bimodal),
      .rsp_correct_total  (rsp_correct_total),
      .rsp_branch_total   (rsp_branch_total),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #6 clock = ~clock;

   function automatic logic [CTR_W-1:0] ctr_toward(input logic [CTR_W-1:0] v, input logic up);
      if (up && v != CTR_MAX) return v + 1'b1;
      if (!up && v != CTR_MIN) return v - 1'b1;
      return v;
   endfunction

   task automatic clear_predictor_state();
      for (int i = 0; i < ENTRIES; i++) begin
         gshare_ctr[i]  = CTR_INIT_PRED;
         bimodal_ctr[i] = CTR_INIT_PRED;
         chooser_ctr[i] = CTR_INIT_CHOOSE;
      end
      global_hist = '0;
      hist_len    = HIST_LEN_RESET;
      correct_cnt = '0;
      branch_cnt  = '0;
   endtask

   // Works out the result of one resolved branch and updates the mirrored tables.
   task automatic predict_branch(input logic [31:0] addr, input logic tk);
      int unsigned       eff_len;
      logic [HIST_W-1:0] mask;
      logic [HIST_W-1:0] hist;
      logic [IDX_W-1:0]  bidx;
      logic [IDX_W-1:0]  gidx;
      logic              gpred;
      logic              bpred;
      logic              pick_b;
      branch_result_type r;
      eff_len = (hist_len > HIST_W) ? HIST_W : hist_len;
      mask    = (HIST_W'(1) << eff_len) - 1'b1;
      hist    = global_hist & mask;
      bidx    = addr[IDX_W-1:0];
      gidx    = IDX_W'(hist) ^ bidx;
      gpred   = gshare_ctr[gidx][1];
      bpred   = bimodal_ctr[bidx][1];
      pick_b  = chooser_ctr[bidx][1];
      r.prediction   = pick_b ? bpred : gpred;
      r.correct      = (r.prediction == tk);
      r.used_bimodal = pick_b;
      gshare_ctr[gidx]  = ctr_toward(gshare_ctr[gidx], tk);
      bimodal_ctr[bidx] = ctr_toward(bimodal_ctr[bidx], tk);
      if (bpred == tk && gpred != tk) begin
         chooser_ctr[bidx] = ctr_toward(chooser_ctr[bidx], 1'b1);
      end else if (gpred == tk && bpred != tk) begin
         chooser_ctr[bidx] = ctr_toward(chooser_ctr[bidx], 1'b0);
      end
      global_hist = {hist[HIST_W-2:0], tk} & mask;
      if (r.correct && correct_cnt != '1) correct_cnt++;
      if (branch_cnt != '1) branch_cnt++;
      r.correct_total = correct_cnt;
      r.branch_total  = branch_cnt;
      expected_results.insert(expected_results.size(), r);
   endtask

   task automatic idle_gap(input int cycles);
      start              <= 1'b0;
      req_branch_address <= $urandom;
      req_taken          <= 1'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // Holds the branch on the request ports until the unit takes it.
   task automatic send_branch(input logic [31:0] addr, input logic tk);
      start              <= 1'b1;
      req_branch_address <= addr;
      req_taken          <= tk;
      do @(posedge clock); while (busy);
      predict_branch(addr, tk);
      sent_count++;
      if (idle_enabled && $urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 12));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   // A setup phase and then an access phase; a read is checked against the mirrored register.
   task automatic csr_access(input bit is_write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (is_write) begin
         if (addr == ADDR_HIST_LEN) hist_len = data[HIST_LEN_W-1:0];
      end else if (prdata !== CSR_DATA_W'(hist_len)) begin
         $display("%0t: history length read, expected %0d, actual %0d", $time, hist_len, prdata);
         error_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_history_length(input logic [HIST_LEN_W-1:0] len);
      logic [CSR_DATA_W-1:0] d;
      d = $urandom;
      d[HIST_LEN_W-1:0] = len;
      drain_results();
      csr_access(1'b1, ADDR_HIST_LEN, d);
      csr_access(1'b0, ADDR_HIST_LEN, '0);
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      branch_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with no transaction outstanding, expected none, actual %0d",
                     $time, rsp_prediction);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("prediction", 32'(want.prediction), 32'(rsp_prediction));
            check_field("correct", 32'(want.correct), 32'(rsp_correct));
            check_field("used_bimodal", 32'(want.used_bimodal), 32'(rsp_used_bimodal));
            check_field("correct_total", want.correct_total, rsp_correct_total);
            check_field("branch_total", want.branch_total, rsp_branch_total);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // The register is reachable during the post-reset sweep; the unmapped word must not alias it.
   task automatic test_register_access();
      csr_access(1'b0, ADDR_HIST_LEN, '0);
      csr_access(1'b1, ADDR_UNMAPPED, $urandom);
      csr_access(1'b0, ADDR_HIST_LEN, '0);
   endtask

   task automatic test_directed_branches();
      send_branch(32'h0000_0000, 1'b0);
      send_branch(32'hFFFF_FFFF, 1'b1);
      // Back-to-back hits on one bimodal and chooser entry saturate the bimodal counter both ways and move the chooser.
      repeat (4) send_branch(32'h0000_0040, 1'b1);
      repeat (4) send_branch(32'h0000_0040, 1'b0);
      send_branch(32'h0000_0840, 1'b1);
      send_branch(32'hABCD_E040, 1'b1);
      send_branch(32'h0000_07FF, 1'b0);
      send_branch(32'hFFFF_F800, 1'b1);
      drain_results();
   endtask

   task automatic test_history_lengths();
      set_history_length(4'd0);
      send_branch(32'h0000_0123, 1'b1);
      send_branch(32'h0000_0123, 1'b0);
      send_branch(32'h0000_0123, 1'b1);
      set_history_length(4'd15);
      send_branch(32'h0000_0123, 1'b1);
      send_branch(32'h8000_0123, 1'b1);
      set_history_length(4'd11);
      repeat (3) send_branch(32'h0000_0456, 1'b1);
      // Shrinking the length leaves longer history in place; only the low bits may count.
      set_history_length(4'd2);
      send_branch(32'h0000_0456, 1'b0);
      send_branch(32'h0000_0457, 1'b1);
      set_history_length(4'd1);
      send_branch(32'h0000_0456, 1'b1);
      send_branch(32'h0000_0456, 1'b0);
   endtask

   task automatic test_random_branches();
      logic [HIST_LEN_W-1:0] phase_len [8];
      logic [31:0]           addr;
      logic                  tk;
      int                    sel;
      int                    slot;
      phase_len = '{4'd11, 4'd0, 4'd1, 4'd15, 4'd5, 4'd12, 4'd3, 4'd11};
      for (int i = 0; i < POOL; i++) begin
         pool_addr[i]    = $urandom;
         // Few distinct low bits, so table entries are shared between branches.
         pool_addr[i][IDX_W-1:0] = IDX_W'($urandom_range(0, 7) * 37);
         pool_pattern[i] = 8'($urandom);
         pool_period[i]  = $urandom_range(1, 8);
         pool_pos[i]     = 0;
      end
      for (int p = 0; p < 8; p++) begin
         set_history_length(phase_len[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 35 == 0) idle_enabled = (p < 7) && ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 9);
            if (sel < 8) begin
               slot = $urandom_range(0, POOL - 1);
               addr = pool_addr[slot];
               tk   = (sel < 6) ? pool_pattern[slot][pool_pos[slot]] : 1'($urandom);
               pool_pos[slot] = (pool_pos[slot] + 1) % pool_period[slot];
            end else begin
               addr = $urandom;
               tk   = 1'($urandom);
            end
            send_branch(addr, tk);
            if (p < 7 && $urandom_range(0, 49) == 0) drain_results();
         end
      end
      idle_enabled = 1'b0;
   endtask

   initial begin
      clear_predictor_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_register_access();
      test_directed_branches();
      test_history_lengths();
      test_random_branches();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d branches: saturation, aliasing, chooser moves, history", sent_count);
      $display("lengths 0 to 15 changed mid-run, register reads and an unmapped register write.");
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### tournament_branch_predictor_unit.f
+incdir+hw/rtl
hw/rtl/tbp_pkg.sv
hw/rtl/tbp_csr.sv
hw/rtl/tbp_ctr_ram.sv
hw/rtl/tournament_branch_predictor_unit.sv
verif/tournament_branch_predictor_unit_test.sv
